// ----- rtl/core/rkgs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkgs_pkg
// Shared constants, types and the radial kernel table for the grid splat block.
// ----------------------------------------------------------------------------
package rkgs_pkg;

   localparam int GRID_W  = 64;
   localparam int GRID_H  = 64;
   localparam int RADIUS  = 4;

   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;
   localparam int KIND_W  = 2;

   localparam int CELL_N  = GRID_W * GRID_H;
   localparam int ADDR_W  = $clog2(CELL_N);

   localparam int KSIZE   = 2 * RADIUS + 1;
   localparam int KERN_N  = KSIZE * KSIZE;
   localparam int KIDX_W  = $clog2(KERN_N);
   localparam int KD_W    = $clog2(RADIUS + 1) + 1;
   localparam int COORD_W = POS_W + 2;
   localparam int KEW     = $clog2(256 * RADIUS + 1);

   localparam int PROD_W  = VALUE_W + KEW + 1;
   localparam int SUM_W   = PROD_W - 7;

   localparam int REQ_DATA_W = ((2 * POS_W + VALUE_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      REQ_FILL  = 2'd0,
      REQ_SPLAT = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef logic [KEW-1:0] kern_tab_type [KERN_N];

   typedef struct packed {
      logic [VALUE_W-1:0] sum;
      logic               sat;
   } alu_res_type;

   // entry = max(0, 256*RADIUS - round(256*sqrt(dx^2+dy^2))), row-major from (-R,-R)
   function automatic kern_tab_type build_kernel();
      kern_tab_type tab;
      longint       n;
      longint       r;
      longint       t;
      int           idx;
      int           top;
      top = 256 * RADIUS;
      idx = 0;
      for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
         for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
            n = longint'(dx * dx + dy * dy) * 65536;
            r = 0;
            for (int b = 15; b >= 0; b--) begin
               t = r | (longint'(1) << b);
               if (t * t <= n) begin
                  r = t;
               end
            end
            if (r * r + r < n) begin
               r = r + 1;
            end
            tab[idx] = (r < longint'(top)) ? KEW'(longint'(top) - r) : '0;
            idx = idx + 1;
         end
      end
      return tab;
   endfunction

   localparam kern_tab_type KERN_TAB = build_kernel();

endpackage

// ----- rtl/core/rkgs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkgs_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rkgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rkgs_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkgs_alu
// Scale times kernel product, Q4.8 to Q16.16 shift and saturating cell add.
// ----------------------------------------------------------------------------
module rkgs_alu (
   input  logic                          clock,
   input  logic [rkgs_pkg::VALUE_W-1:0]  scale,
   input  logic [rkgs_pkg::KEW-1:0]      kern,
   input  logic [rkgs_pkg::VALUE_W-1:0]  grid_val,
   output rkgs_pkg::alu_res_type         res
);
   import rkgs_pkg::*;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sum;
   logic                     fits;

   // product is registered and ready in the cycle after issue, lined up with the read data
   assign prod_in = PROD_W'($signed(scale)) * PROD_W'($signed({1'b0, kern}));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift right by 8 rounds toward minus infinity
   assign sum  = SUM_W'($signed(grid_val)) + SUM_W'($signed(prod_ff[PROD_W-1:8]));
   assign fits = (&sum[SUM_W-1:VALUE_W-1]) || ~(|sum[SUM_W-1:VALUE_W-1]);

   always_comb begin
      res.sat = ~fits;
      if (fits) begin
         res.sum = sum[VALUE_W-1:0];
      end else if (sum[SUM_W-1]) begin
         res.sum = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         res.sum = {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

endmodule

// ----- rtl/core/radial_kernel_grid_splat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_kernel_grid_splat
// Grid of Q16.16 cells in one RAM with fill, radial-kernel splat and read.
// ----------------------------------------------------------------------------
// steps: splat does a read-modify-write for each of the 2*RADIUS+1 squared
//   kernel cells, then drain and response; fill writes every cell, then response;
//   read waits for the RAM read data, then response; unused code goes to response
// one request at a time; the single RAM read port walks the cells
// a result waits in an output register while the next request is taken
// reset clears control only; grid cells hold garbage until the first fill
// ----------------------------------------------------------------------------
module radial_kernel_grid_splat (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // x_pos, y_pos, value, zero pad
   input  logic [rkgs_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [rkgs_pkg::KIND_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cell_value
   output logic [rkgs_pkg::VALUE_W-1:0]    rsp_tdata,
   // saturated
   output logic                            rsp_tuser
);
   import rkgs_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FILL   = 6'b000010,
      ST_SPLAT  = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_RDWAIT = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [POS_W-1:0]        xc_ff, xc_in;
   logic [POS_W-1:0]        yc_ff, yc_in;
   logic [VALUE_W-1:0]      value_ff, value_in;
   logic [ADDR_W-1:0]       fill_addr_ff, fill_addr_in;
   logic signed [KD_W-1:0]  dx_ff, dx_in;
   logic signed [KD_W-1:0]  dy_ff, dy_in;
   logic [KIDX_W-1:0]       kidx_ff, kidx_in;
   logic                    wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]       wr_addr_ff, wr_addr_in;
   logic                    sat_ff, sat_in;
   logic [VALUE_W-1:0]      res_ff, res_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   logic [POS_W-1:0]        x_req;
   logic [POS_W-1:0]        y_req;
   logic [VALUE_W-1:0]      value_req;
   logic                    req_fire;
   logic signed [COORD_W-1:0] xs;
   logic signed [COORD_W-1:0] ys;
   logic                    in_grid;
   logic [ADDR_W-1:0]       splat_addr;
   logic [ADDR_W-1:0]       read_addr;
   logic                    mem_wr_en;
   logic [ADDR_W-1:0]       mem_wr_addr;
   logic [VALUE_W-1:0]      mem_wr_data;
   logic [ADDR_W-1:0]       mem_rd_addr;
   logic [VALUE_W-1:0]      mem_rd_data;
   alu_res_type             alu_res;

   assign x_req     = req_tdata[POS_W-1:0];
   assign y_req     = req_tdata[2*POS_W-1:POS_W];
   assign value_req = req_tdata[2*POS_W+VALUE_W-1:2*POS_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // kernel cell position around the center
   assign xs = $signed({2'b00, xc_ff}) + COORD_W'(dx_ff);
   assign ys = $signed({2'b00, yc_ff}) + COORD_W'(dy_ff);
   assign in_grid = !xs[COORD_W-1] && !ys[COORD_W-1] &&
                    (int'(xs) < GRID_W) && (int'(ys) < GRID_H);
   assign splat_addr = ADDR_W'(int'(ys) * GRID_W + int'(xs));
   assign read_addr  = ADDR_W'(int'(y_req) * GRID_W + int'(x_req));

   always_comb begin
      mem_rd_addr = (state_ff == ST_SPLAT) ? splat_addr : read_addr;
      if (state_ff == ST_FILL) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = fill_addr_ff;
         mem_wr_data = value_ff;
      end else begin
         mem_wr_en   = wr_pend_ff;
         mem_wr_addr = wr_addr_ff;
         mem_wr_data = alu_res.sum;
      end
   end

   rkgs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CELL_N)
   ) u_grid (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rkgs_alu u_alu (
      .clock    (clock),
      .scale    (value_ff),
      .kern     (KERN_TAB[kidx_ff]),
      .grid_val (mem_rd_data),
      .res      (alu_res)
   );

   always_comb begin
      state_in     = state_ff;
      xc_in        = xc_ff;
      yc_in        = yc_ff;
      value_in     = value_ff;
      fill_addr_in = fill_addr_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      kidx_in      = kidx_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = splat_addr;
      sat_in       = sat_ff | (wr_pend_ff & alu_res.sat);
      res_in       = res_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               xc_in        = x_req;
               yc_in        = y_req;
               value_in     = value_req;
               fill_addr_in = '0;
               dx_in        = KD_W'(-RADIUS);
               dy_in        = KD_W'(-RADIUS);
               kidx_in      = '0;
               sat_in       = 1'b0;
               res_in       = '0;
               rd_ok_in     = (int'(x_req) < GRID_W) && (int'(y_req) < GRID_H);
               case (req_kind_type'(req_tuser))
                  REQ_FILL:  state_in = ST_FILL;
                  REQ_SPLAT: state_in = ST_SPLAT;
                  REQ_READ:  state_in = ST_RDWAIT;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_FILL: begin
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == ADDR_W'(CELL_N - 1)) begin
               state_in = ST_RESP;
            end
         end
         ST_SPLAT: begin
            wr_pend_in = in_grid;
            kidx_in    = kidx_ff + 1'b1;
            if (dx_ff == KD_W'(RADIUS)) begin
               dx_in = KD_W'(-RADIUS);
               dy_in = dy_ff + 1'b1;
               if (dy_ff == KD_W'(RADIUS)) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               dx_in = dx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RDWAIT: begin
            res_in   = rd_ok_ff ? mem_rd_data : '0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xc_ff        <= xc_in;
      yc_ff        <= yc_in;
      value_ff     <= value_in;
      fill_addr_ff <= fill_addr_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      kidx_ff      <= kidx_in;
      wr_addr_ff   <= wr_addr_in;
      sat_ff       <= sat_in;
      res_ff       <= res_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule
